### rtl/complex_arithmetic_unit_core_macros.svh
// Assertion macros shared by the complex arithmetic unit files.
`ifndef COMPLEX_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_CORE_MACROS_SVH
`ifndef SYNTH
`define CAU_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define CAU_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define CAU_ASSERT_IMP(label, clk, rst_n, a, c)
`define CAU_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

### rtl/cau_pkg.sv
`timescale 1ns / 1ps
package cau_pkg;
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS = 16;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MAG = 3'd4,
        OP_CMP = 3'd5
    } t_opcode;

    typedef struct packed {
        logic [2:0] opcode;
        logic signed [DATA_WIDTH-1:0] a_re;
        logic signed [DATA_WIDTH-1:0] a_im;
        logic signed [DATA_WIDTH-1:0] b_re;
        logic signed [DATA_WIDTH-1:0] b_im;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] res_re;
        logic signed [DATA_WIDTH-1:0] res_im;
        logic is_equal;
        logic error;
    } t_out_word;

    // Classified word handed from the front end to the back end.
    typedef struct packed {
        logic is_add;
        logic is_sub;
        logic is_mul;
        logic is_div;
        logic is_mag;
        logic is_cmp;
        logic is_bad;
        logic equal;
        logic signed [DATA_WIDTH-1:0] a_re;
        logic signed [DATA_WIDTH-1:0] a_im;
        logic signed [DATA_WIDTH-1:0] b_re;
        logic signed [DATA_WIDTH-1:0] b_im;
    } t_cls_word;
endpackage

### rtl/complex_arithmetic_unit_core.sv
`timescale 1ns / 1ps
// Complex arithmetic unit on signed fixed point operands.
// Input channel: drive i_word and raise start; a word is taken at a clock
// edge where start is high and busy is low.
// Output channel: o_valid is high for one cycle with the result on o_word.
// The receiver cannot stall, so results are never held.
// The front end classifies each word and pushes it into a four-entry queue.
// The back end takes one word at a time from the queue and runs a fixed
// sequence: products, a bit-serial divider for each quotient part, and a
// bit-serial square root.
// The back end pops no new word until it has finished the last one;
// busy is high while the queue is full.
// A synchronous active-low reset empties the queue and idles the back end.
module complex_arithmetic_unit_core #(
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  cau_pkg::t_in_word  i_word,
    output logic               busy,
    output logic               o_valid,
    output cau_pkg::t_out_word o_word
);
    logic w_push, w_full, w_empty, w_pop;
    cau_pkg::t_cls_word w_cls, w_qword;

    cau_front u_front (
        .i_start(start), .i_word(i_word),
        .i_full(w_full), .o_busy(busy), .o_push(w_push), .o_cls(w_cls)
    );

    cau_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push),
        .i_word(w_cls), .i_pop(w_pop), .o_full(w_full), .o_empty(w_empty),
        .o_word(w_qword)
    );

    cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(w_empty),
        .i_word(w_qword), .o_pop(w_pop), .o_valid(o_valid), .o_word(o_word)
    );
endmodule

### rtl/cau_front.sv
`timescale 1ns / 1ps
module cau_front (
    input  logic                  i_start,
    input  cau_pkg::t_in_word     i_word,
    input  logic                  i_full,
    output logic                  o_busy,
    output logic                  o_push,
    output cau_pkg::t_cls_word    o_cls
);
    assign o_busy = i_full;
    assign o_push = i_start && !i_full;

    always_comb begin
        o_cls        = '0;
        o_cls.a_re   = i_word.a_re;
        o_cls.a_im   = i_word.a_im;
        o_cls.b_re   = i_word.b_re;
        o_cls.b_im   = i_word.b_im;
        o_cls.equal  = (i_word.a_re == i_word.b_re) && (i_word.a_im == i_word.b_im);
        unique case (i_word.opcode)
            cau_pkg::OP_ADD: o_cls.is_add = 1'b1;
            cau_pkg::OP_SUB: o_cls.is_sub = 1'b1;
            cau_pkg::OP_MUL: o_cls.is_mul = 1'b1;
            cau_pkg::OP_DIV: o_cls.is_div = 1'b1;
            cau_pkg::OP_MAG: o_cls.is_mag = 1'b1;
            cau_pkg::OP_CMP: o_cls.is_cmp = 1'b1;
            default:         o_cls.is_bad = 1'b1;
        endcase
    end
endmodule

### rtl/cau_queue.sv
`timescale 1ns / 1ps
`include "complex_arithmetic_unit_core_macros.svh"
module cau_queue #(
    parameter int DEPTH = cau_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  cau_pkg::t_cls_word i_word,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_empty,
    output cau_pkg::t_cls_word o_word
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    cau_pkg::t_cls_word r_mem [DEPTH];
    logic [AW-1:0]      r_wp, r_rp;
    logic [AW:0]        r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_word  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    `CAU_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `CAU_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty)
    `CAU_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= (AW+1)'(DEPTH))
endmodule

### rtl/cau_back.sv
`timescale 1ns / 1ps
`include "complex_arithmetic_unit_core_macros.svh"
module cau_back #(
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  cau_pkg::t_cls_word i_word,
    output logic               o_pop,
    output logic               o_valid,
    output cau_pkg::t_out_word o_word
);
    localparam int W  = cau_pkg::DATA_WIDTH;
    localparam int PW = 2 * W + 2;
    localparam int NW = PW + FRAC_BITS;
    localparam int SQ = W + 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    typedef enum logic [7:0] {
        P_PROD = 8'b0000_0001,
        P_SUM  = 8'b0000_0010,
        P_PREP = 8'b0000_0100,
        P_DIV  = 8'b0000_1000,
        P_NEXT = 8'b0001_0000,
        P_QIM  = 8'b0010_0000,
        P_SQRT = 8'b0100_0000,
        P_DONE = 8'b1000_0000
    } t_phase;

    t_state r_state, n_state;
    t_phase r_phase;
    logic [7:0] r_cnt;
    cau_pkg::t_cls_word r_op;
    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [PW:0] r_nre, r_nim;
    logic [PW-1:0] r_den;
    logic [NW-1:0] r_qn;
    logic [NW:0] r_rem;
    logic [NW-1:0] r_q;
    logic r_qneg;
    logic r_which;
    logic signed [NW:0] r_qre, r_qim;
    logic [PW-1:0] r_sqv;
    logic [SQ-1:0] r_root;
    logic [PW+1:0] r_sqr;
    cau_pkg::t_out_word r_out, n_out;
    logic r_valid;

    logic [NW:0] w_rsh;
    logic [PW+1:0] w_st, w_trial;
    logic signed [NW:0] w_re, w_im;
    logic [W:0] w_sre, w_sim;

    assign w_rsh = {r_rem[NW-1:0], r_qn[NW-1]};
    assign w_st  = {r_sqr[PW-1:0], r_sqv[PW-1:PW-2]};
    assign w_trial = (PW+2)'({r_root, 2'b01});
    assign o_pop   = (r_state == S_IDLE) && !i_empty;
    assign o_valid = r_valid;
    assign o_word  = r_out;

    // The top bit of the result flags saturation.
    function automatic logic [W:0] f_sat(input logic signed [NW:0] v);
        logic signed [NW:0] hi, lo;
        hi = (NW+1)'((64'sd1 <<< (W - 1)) - 1);
        lo = -(NW+1)'(64'sd1 <<< (W - 1));
        if (v > hi) begin
            return {1'b1, hi[W-1:0]};
        end else if (v < lo) begin
            return {1'b1, lo[W-1:0]};
        end
        return {1'b0, v[W-1:0]};
    endfunction

    always_comb begin
        w_re = '0;
        w_im = '0;
        if (r_op.is_add) begin
            w_re = (NW+1)'(r_op.a_re) + (NW+1)'(r_op.b_re);
            w_im = (NW+1)'(r_op.a_im) + (NW+1)'(r_op.b_im);
        end else if (r_op.is_sub) begin
            w_re = (NW+1)'(r_op.a_re) - (NW+1)'(r_op.b_re);
            w_im = (NW+1)'(r_op.a_im) - (NW+1)'(r_op.b_im);
        end else if (r_op.is_mul) begin
            // The product drops its fraction toward zero.
            w_re = r_nre[PW] ? -(((NW+1)'(-r_nre)) >>> FRAC_BITS)
                             : (((NW+1)'(r_nre)) >>> FRAC_BITS);
            w_im = r_nim[PW] ? -(((NW+1)'(-r_nim)) >>> FRAC_BITS)
                             : (((NW+1)'(r_nim)) >>> FRAC_BITS);
        end else if (r_op.is_div && (r_den != '0)) begin
            w_re = r_qre;
            w_im = r_qim;
        end else if (r_op.is_mag) begin
            w_re = (NW+1)'(r_root);
        end
    end

    assign w_sre = f_sat(w_re);
    assign w_sim = f_sat(w_im);

    always_comb begin
        n_out          = '0;
        n_out.res_re   = w_sre[W-1:0];
        n_out.res_im   = w_sim[W-1:0];
        n_out.is_equal = r_op.is_cmp & r_op.equal;
        n_out.error    = w_sre[W] | w_sim[W] | r_op.is_bad
                       | (r_op.is_div & (r_den == '0));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (!i_empty) n_state = S_RUN;
            S_RUN:  if (r_phase == P_DONE) n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_phase <= P_PROD;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_OUT);
            if (o_pop) begin
                r_phase <= P_PROD;
                r_cnt <= '0;
            end
            if (r_state == S_RUN) begin
                unique case (r_phase)
                    P_PROD: r_phase <= P_SUM;
                    P_SUM:  r_phase <= P_PREP;
                    P_PREP: r_phase <= P_DIV;
                    P_DIV: begin
                        if (r_cnt == 8'(NW - 1)) begin
                            r_cnt <= '0;
                            r_phase <= r_which ? P_QIM : P_NEXT;
                        end else begin
                            r_cnt <= r_cnt + 8'd1;
                        end
                    end
                    P_NEXT: r_phase <= P_DIV;
                    P_QIM:  r_phase <= P_SQRT;
                    P_SQRT: begin
                        r_cnt <= r_cnt + 8'd1;
                        if (r_cnt == 8'(SQ - 1)) r_phase <= P_DONE;
                    end
                    default: r_phase <= r_phase;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [NW:0] qv;
        qv = (NW+1)'(r_q);
        if (o_pop) begin
            r_op <= i_word;
            r_which <= 1'b0;
        end
        if (r_state == S_RUN) begin
            unique case (r_phase)
                P_PROD: begin
                    r_p0 <= PW'(r_op.a_re * r_op.b_re);
                    r_p1 <= PW'(r_op.a_im * r_op.b_im);
                    r_p2 <= PW'(r_op.a_im * r_op.b_re);
                    r_p3 <= PW'(r_op.a_re * r_op.b_im);
                end
                P_SUM: begin
                    r_nre <= r_op.is_div ? (PW+1)'(r_p0) + (PW+1)'(r_p1)
                                         : (PW+1)'(r_p0) - (PW+1)'(r_p1);
                    r_nim <= r_op.is_div ? (PW+1)'(r_p2) - (PW+1)'(r_p3)
                                         : (PW+1)'(r_p2) + (PW+1)'(r_p3);
                    r_p0 <= PW'(r_op.b_re * r_op.b_re);
                    r_p1 <= PW'(r_op.b_im * r_op.b_im);
                    r_p2 <= PW'(r_op.a_re * r_op.a_re);
                    r_p3 <= PW'(r_op.a_im * r_op.a_im);
                end
                P_PREP: begin
                    r_den <= r_p0 + r_p1;
                    r_sqv <= r_p2 + r_p3;
                    r_sqr <= '0;
                    r_root <= '0;
                    r_qneg <= r_nre[PW];
                    r_qn <= NW'(r_nre[PW] ? -r_nre : r_nre) << FRAC_BITS;
                    r_rem <= '0;
                    r_q <= '0;
                end
                P_DIV: begin
                    if (w_rsh >= (NW+1)'(r_den)) begin
                        r_rem <= w_rsh - (NW+1)'(r_den);
                        r_q <= {r_q[NW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_rsh;
                        r_q <= {r_q[NW-2:0], 1'b0};
                    end
                    r_qn <= r_qn << 1;
                end
                P_NEXT: begin
                    r_qre <= r_qneg ? -qv : qv;
                    r_which <= 1'b1;
                    r_qneg <= r_nim[PW];
                    r_qn <= NW'(r_nim[PW] ? -r_nim : r_nim) << FRAC_BITS;
                    r_rem <= '0;
                    r_q <= '0;
                end
                P_QIM: begin
                    r_qim <= r_qneg ? -qv : qv;
                end
                P_SQRT: begin
                    if (w_st >= w_trial) begin
                        r_sqr <= w_st - w_trial;
                        r_root <= {r_root[SQ-2:0], 1'b1};
                    end else begin
                        r_sqr <= w_st;
                        r_root <= {r_root[SQ-2:0], 1'b0};
                    end
                    r_sqv <= r_sqv << 2;
                end
                P_DONE: begin
                    r_out <= n_out;
                end
                default: begin
                end
            endcase
        end
    end

    `CAU_ASSERT_NXT(a_out_after_run, i_clk, i_rst_n, r_state == S_OUT, r_valid)
    `CAU_ASSERT_IMP(a_pop_idle, i_clk, i_rst_n, o_pop, r_state == S_IDLE)
    `CAU_ASSERT_IMP(a_state_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_state))
endmodule
